### hw/rtl/rtsp_pkg.sv
package rtsp_pkg;

    // width of the bulk length limit register
    localparam int MAX_LEN_W = 30;

    // results one byte may cause, and result queue depth
    localparam int PUSH_MAX = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int COUNT_W = 3;

    typedef enum logic [2:0] {
        KIND_SIMPLE     = 3'd0,
        KIND_ERROR      = 3'd1,
        KIND_INTEGER    = 3'd2,
        KIND_BULK       = 3'd3,
        KIND_NULL       = 3'd4,
        KIND_INCOMPLETE = 3'd5,
        KIND_BAD_LENGTH = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LINE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_BULK    = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DROP    = 3'd5
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       last;
    } t_result;

    // queue control between the parser and the result queue
    typedef struct packed {
        logic [1:0] push_n;
        logic       pop;
    } t_queue_ctrl;

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] TRAILER_LEN = 2'd2;

endpackage

### hw/rtl/rtsp_in_if.sv
interface rtsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, data_byte, end_of_buffer, input ready);
    modport sink (input valid, data_byte, end_of_buffer, output ready);
endinterface

### hw/rtl/rtsp_out_if.sv
interface rtsp_out_if;
    import rtsp_pkg::*;

    logic       valid;
    logic       ready;
    t_kind      kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       last;

    modport source (output valid, kind, out_byte, byte_valid, token_end, last, input ready);
    modport sink (input valid, kind, out_byte, byte_valid, token_end, last, output ready);
endinterface

### hw/rtl/rtsp_cfg_if.sv
interface rtsp_cfg_if;
    import rtsp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MAX_LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hw/rtl/rtsp_queue.sv
module rtsp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtsp_pkg::t_result     i_push [rtsp_pkg::PUSH_MAX],
    input  rtsp_pkg::t_queue_ctrl i_ctrl,
    output rtsp_pkg::t_result     o_head,
    output logic [rtsp_pkg::COUNT_W-1:0] o_count
);
    import rtsp_pkg::*;

    t_result              r_q [QUEUE_DEPTH];
    t_result              n_q [QUEUE_DEPTH];
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic [COUNT_W-1:0]   w_base;

    // shift out the head on pop, then append new results behind what is left
    always_comb begin
        logic [COUNT_W-1:0] off;
        w_base = r_count - COUNT_W'(i_ctrl.pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_ctrl.pop && (i < QUEUE_DEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            off = COUNT_W'(i) - w_base;
            if ((COUNT_W'(i) >= w_base) && (off < COUNT_W'(i_ctrl.push_n))) begin
                n_q[i] = i_push[off[1:0]];
            end
        end
        n_count = w_base + COUNT_W'(i_ctrl.push_n);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = r_q[0];
    assign o_count = r_count;

endmodule

### hw/rtl/resp_token_stream_parser_core.sv
// resp2 token stream parser: takes one protocol byte per transaction, with
// end_of_buffer on the buffer's final byte, and returns tagged content bytes
// and markers (token end, null bulk, incomplete, bad length) on the output
// channel, one result per transaction. the parser state is updated in the
// same cycle a byte is accepted and all results of that byte (up to three)
// go into a four-entry result queue, so a byte is taken every cycle as long
// as the queue holds at most one result; the single result port sets the
// rate, so the results of one byte leave one at a time. the bulk
// length limit is written through the configuration channel, which is always
// ready; write it only while the parser is idle. reset value is 2^29.
module resp_token_stream_parser_core #(
    parameter int LENGTH_BITS = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtsp_in_if.sink           i_in,
    rtsp_out_if.source        o_out,
    rtsp_cfg_if.sink          i_cfg
);
    import rtsp_pkg::*;

    localparam int ACC_W = LENGTH_BITS + 4;
    localparam int CMP_W = 32;
    localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    // parser state
    t_phase                  r_phase,   n_phase;
    logic [1:0]              r_tkind,   n_tkind;
    logic                    r_cr,      n_cr;
    logic [LENGTH_BITS-1:0]  r_acc,     n_acc;
    logic                    r_neg,     n_neg;
    logic                    r_seen,    n_seen;
    logic                    r_stop,    n_stop;
    logic [1:0]              r_trail,   n_trail;
    logic [MAX_LEN_W-1:0]    r_max_len;

    logic                    w_accept;
    logic [7:0]              w_b;
    logic                    w_is_cr;
    logic                    w_is_lf;
    logic                    w_is_digit;
    logic [3:0]              w_digit;
    logic [ACC_W-1:0]        w_acc_prod;
    logic [LENGTH_BITS-1:0]  w_acc_dig;
    logic                    w_len_null;
    logic                    w_len_bad;
    logic                    w_len_zero;
    t_phase                  w_phase_pre;

    t_result                 w_res [PUSH_MAX];
    logic [1:0]              w_res_n;
    t_queue_ctrl             w_qctrl;
    t_result                 w_head;
    logic [COUNT_W-1:0]      w_count;

    function automatic t_result make_res(t_kind kind, logic [7:0] b, logic valid,
                                         logic tend);
        t_result r;
        r.kind       = kind;
        r.out_byte   = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.token_end  = tend;
        r.last       = 1'b0;
        return r;
    endfunction

    // byte decode
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.data_byte;
    assign w_is_cr    = (w_b == CH_CR);
    assign w_is_lf    = (w_b == CH_LF);
    assign w_is_digit = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
    assign w_digit    = 4'(w_b - CH_ZERO);

    // decimal accumulate, saturating at all ones
    assign w_acc_prod = (ACC_W'(r_acc) << 3) + (ACC_W'(r_acc) << 1) + ACC_W'(w_digit);
    assign w_acc_dig  = (w_acc_prod > ACC_W'(LEN_SAT)) ? LEN_SAT
                                                       : w_acc_prod[LENGTH_BITS-1:0];

    // length line verdict at its lf; -1 is null, -0 counts as zero
    assign w_len_null = r_seen && r_neg && (r_acc == LEN_ONE);
    assign w_len_bad  = !r_seen || (!w_len_null && ((r_neg && (r_acc != '0)) ||
                        (r_acc == LEN_SAT) || (CMP_W'(r_acc) > CMP_W'(r_max_len))));
    assign w_len_zero = !w_len_bad && !w_len_null && (r_acc == '0);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_tkind = r_tkind;
        n_cr    = r_cr;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_stop  = r_stop;
        n_trail = r_trail;

        case (r_phase)
            PH_LINE: begin
                if (r_cr && w_is_lf) begin
                    n_phase = PH_IDLE;
                    n_tkind = '0;
                    n_cr    = 1'b0;
                end else begin
                    n_cr = w_is_cr;
                end
            end
            PH_LEN: begin
                if (r_cr && w_is_lf) begin
                    n_cr   = 1'b0;
                    n_neg  = 1'b0;
                    n_seen = 1'b0;
                    n_stop = 1'b0;
                    if (w_len_null || w_len_bad) begin
                        n_phase = w_len_null ? PH_IDLE : PH_DROP;
                        n_tkind = '0;
                        n_acc   = '0;
                    end else if (w_len_zero) begin
                        n_phase = PH_TRAILER;
                        n_trail = TRAILER_LEN;
                    end else begin
                        n_phase = PH_BULK;
                    end
                end else if (r_cr) begin
                    // a lone cr ends the digit run; whatever follows is ignored
                    n_stop = 1'b1;
                    n_cr   = w_is_cr;
                end else if (w_is_cr) begin
                    n_cr = 1'b1;
                end else if (w_is_digit) begin
                    if (!r_stop) begin
                        n_acc  = w_acc_dig;
                        n_seen = 1'b1;
                    end
                end else if ((w_b == CH_MINUS) && !r_seen && !r_stop && !r_neg) begin
                    n_neg = 1'b1;
                end else begin
                    n_stop = 1'b1;
                end
            end
            PH_BULK: begin
                n_acc = r_acc - LEN_ONE;
                if (r_acc == LEN_ONE) begin
                    n_phase = PH_TRAILER;
                    n_trail = TRAILER_LEN;
                end
            end
            PH_TRAILER: begin
                n_trail = r_trail - 2'd1;
                if (r_trail == 2'd1) begin
                    n_phase = PH_IDLE;
                    n_tkind = '0;
                end
            end
            PH_DROP: begin
                n_phase = PH_DROP;
            end
            default: begin
                n_phase = PH_IDLE;
                n_tkind = '0;
                n_cr    = 1'b0;
                n_acc   = '0;
                n_neg   = 1'b0;
                n_seen  = 1'b0;
                n_stop  = 1'b0;
                n_trail = '0;
                case (w_b)
                    CH_PLUS: begin
                        n_phase = PH_LINE;
                        n_tkind = 2'(KIND_SIMPLE);
                    end
                    CH_MINUS: begin
                        n_phase = PH_LINE;
                        n_tkind = 2'(KIND_ERROR);
                    end
                    CH_COLON: begin
                        n_phase = PH_LINE;
                        n_tkind = 2'(KIND_INTEGER);
                    end
                    CH_DOLLAR: begin
                        n_phase = PH_LEN;
                        n_tkind = 2'(KIND_BULK);
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        endcase

        w_phase_pre = n_phase;

        // buffer end returns everything to reset
        if (i_in.end_of_buffer) begin
            n_phase = PH_IDLE;
            n_tkind = '0;
            n_cr    = 1'b0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_seen  = 1'b0;
            n_stop  = 1'b0;
            n_trail = '0;
        end
    end

    // results of the byte
    always_comb begin
        logic [1:0] idx;
        t_kind      tk;
        idx = 2'd0;
        tk  = t_kind'({1'b0, r_tkind});
        for (int i = 0; i < PUSH_MAX; i++) begin
            w_res[i] = make_res(KIND_SIMPLE, 8'h00, 1'b0, 1'b0);
        end

        case (r_phase)
            PH_LINE: begin
                if (r_cr && w_is_lf) begin
                    w_res[idx] = make_res(tk, 8'h00, 1'b0, 1'b1);
                    idx = idx + 2'd1;
                end else begin
                    if (r_cr) begin
                        // held cr turns out to be content
                        w_res[idx] = make_res(tk, CH_CR, 1'b1, 1'b0);
                        idx = idx + 2'd1;
                    end
                    if (!w_is_cr) begin
                        w_res[idx] = make_res(tk, w_b, 1'b1, 1'b0);
                        idx = idx + 2'd1;
                    end
                end
            end
            PH_LEN: begin
                if (r_cr && w_is_lf) begin
                    if (w_len_null) begin
                        w_res[idx] = make_res(KIND_NULL, 8'h00, 1'b0, 1'b1);
                        idx = idx + 2'd1;
                    end else if (w_len_bad) begin
                        w_res[idx] = make_res(KIND_BAD_LENGTH, 8'h00, 1'b0, 1'b1);
                        idx = idx + 2'd1;
                    end else if (w_len_zero) begin
                        w_res[idx] = make_res(KIND_BULK, 8'h00, 1'b0, 1'b1);
                        idx = idx + 2'd1;
                    end
                end
            end
            PH_BULK: begin
                w_res[idx] = make_res(KIND_BULK, w_b, 1'b1, r_acc == LEN_ONE);
                idx = idx + 2'd1;
            end
            default: begin
                idx = 2'd0;
            end
        endcase

        if (i_in.end_of_buffer && ((w_phase_pre == PH_LINE) || (w_phase_pre == PH_LEN) ||
                                   (w_phase_pre == PH_BULK))) begin
            w_res[idx] = make_res(KIND_INCOMPLETE, 8'h00, 1'b0, 1'b1);
            idx = idx + 2'd1;
        end

        if (idx != 2'd0) begin
            w_res[idx - 2'd1].last = 1'b1;
        end
        w_res_n = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tkind <= '0;
            r_cr    <= 1'b0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_stop  <= 1'b0;
            r_trail <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_tkind <= n_tkind;
            r_cr    <= n_cr;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_stop  <= n_stop;
            r_trail <= n_trail;
        end
    end

    // bulk length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_W'(1) << 29;
        end else if (i_cfg.valid) begin
            r_max_len <= i_cfg.data;
        end
    end
    assign i_cfg.ready = 1'b1;

    // result queue: room for three more results when it holds at most one
    assign w_qctrl.push_n = w_accept ? w_res_n : 2'd0;
    assign w_qctrl.pop    = o_out.valid && o_out.ready;

    rtsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res),
        .i_ctrl  (w_qctrl),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign i_in.ready       = (w_count <= COUNT_W'(1));
    assign o_out.valid      = (w_count != '0);
    assign o_out.kind       = w_head.kind;
    assign o_out.out_byte   = w_head.out_byte;
    assign o_out.byte_valid = w_head.byte_valid;
    assign o_out.token_end  = w_head.token_end;
    assign o_out.last       = w_head.last;

endmodule

### hw/rtl/rtsp_checker.sv
module rtsp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // input back-pressure only comes from queued results
    a_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty result queue");

    // all results of one byte are queued together
    a_burst_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside the results of one byte");

endmodule

bind resp_token_stream_parser_core rtsp_checker u_rtsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last)
);

### dv/tb_top.sv
module tb_top;
    import rtsp_pkg::*;

    // run shape
    localparam int N_DIRECTED    = 31;
    localparam int N_PHASES      = 5;
    localparam int PHASE_BYTES   = 80;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 8;

    // accumulator saturation point, as for the default LENGTH_BITS of 30
    localparam longint unsigned LEN_SAT = (64'd1 << 30) - 64'd1;
    localparam logic [MAX_LEN_W-1:0] RESET_LIMIT = 30'd536870912;
    localparam logic [MAX_LEN_W-1:0] TOP_LIMIT   = 30'h3fffffff;

    localparam t_result NO_RESULT = '{KIND_SIMPLE, 8'h00, 1'b0, 1'b0, 1'b0};

    // one byte of the protocol stream, with an optional hand-typed expectation
    typedef struct {
        logic [7:0] data;
        logic       eob;
        logic       typed;
        t_result    typed_res;
    } t_feed_byte;

    logic i_clk;
    logic i_rst_n;

    rtsp_in_if  in_ch ();
    rtsp_out_if out_ch ();
    rtsp_cfg_if cfg_ch ();

    resp_token_stream_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // parser shadow state and the bulk length limit it was last given
    // ------------------------------------------------------------------
    t_phase          ps_phase;
    t_kind           ps_kind;
    logic            ps_cr_held;
    longint unsigned ps_count;
    logic            ps_neg;
    logic            ps_digits;
    logic            ps_stopped;
    logic [1:0]      ps_trailer;
    logic [MAX_LEN_W-1:0] bulk_limit;

    t_result    byte_results[$];     // results of the byte just parsed
    t_result    pending_results[$];  // results still owed by the block
    t_feed_byte feed_q[$];           // bytes waiting to be offered
    logic [7:0] draft[$];            // buffer under construction
    t_feed_byte cur_item;            // byte on the input channel right now
    t_feed_byte directed_rows [N_DIRECTED];

    int  mismatches;
    int  results_checked;
    int  bytes_accepted;
    int  buffers_planned;
    int  limit_writes;
    logic hold_req;

    // ------------------------------------------------------------------
    // shadow parser
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        ps_phase   = PH_IDLE;
        ps_kind    = KIND_SIMPLE;
        ps_cr_held = 1'b0;
        ps_count   = 0;
        ps_neg     = 1'b0;
        ps_digits  = 1'b0;
        ps_stopped = 1'b0;
        ps_trailer = 2'd0;
    endfunction

    function automatic void add_result(t_kind k, logic [7:0] b, logic v, logic e);
        t_result r;
        r.kind       = k;
        r.out_byte   = v ? b : 8'h00;
        r.byte_valid = v;
        r.token_end  = e;
        r.last       = 1'b0;
        byte_results.insert(byte_results.size(), r);
    endfunction

    // one character of a bulk length line: digits accumulate (saturating),
    // a leading minus sets the sign, anything else freezes the value
    function automatic void length_char(logic [7:0] b);
        longint unsigned v;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (!ps_stopped) begin
                v = ps_count * 10 + longint'(b - CH_ZERO);
                ps_count  = (v > LEN_SAT) ? LEN_SAT : v;
                ps_digits = 1'b1;
            end
        end else if (b == CH_MINUS && !ps_digits && !ps_stopped && !ps_neg) begin
            ps_neg = 1'b1;
        end else begin
            ps_stopped = 1'b1;
        end
    endfunction

    // CR LF closing a length line: null bulk, bad length, zero or real bulk
    function automatic void finish_length();
        longint unsigned n;
        logic bad;
        n   = ps_count;
        bad = !ps_digits;
        if (!bad && ps_neg && n == 1) begin
            add_result(KIND_NULL, 8'h00, 1'b0, 1'b1);
            clear_parse();
        end else begin
            if (!bad && ps_neg && n != 0)
                bad = 1'b1;
            if (!bad && (n >= LEN_SAT || n > bulk_limit))
                bad = 1'b1;
            if (bad) begin
                add_result(KIND_BAD_LENGTH, 8'h00, 1'b0, 1'b1);
                clear_parse();
                ps_phase = PH_DROP;
            end else begin
                ps_cr_held = 1'b0;
                ps_neg     = 1'b0;
                ps_digits  = 1'b0;
                ps_stopped = 1'b0;
                if (n == 0) begin
                    add_result(KIND_BULK, 8'h00, 1'b0, 1'b1);
                    ps_phase   = PH_TRAILER;
                    ps_trailer = TRAILER_LEN;
                end else begin
                    ps_count = n;
                    ps_phase = PH_BULK;
                end
            end
        end
    endfunction

    // works out every result that one stream byte causes
    function automatic void resp_parse_byte(logic [7:0] b, logic eob);
        logic done;
        t_result r;
        byte_results.delete();
        done = 1'b0;
        case (ps_phase)
            PH_LINE: begin
                if (ps_cr_held) begin
                    if (b == CH_LF) begin
                        add_result(ps_kind, 8'h00, 1'b0, 1'b1);
                        clear_parse();
                        done = 1'b1;
                    end else begin
                        add_result(ps_kind, CH_CR, 1'b1, 1'b0);
                        ps_cr_held = 1'b0;
                    end
                end
                if (!done) begin
                    if (b == CH_CR)
                        ps_cr_held = 1'b1;
                    else
                        add_result(ps_kind, b, 1'b1, 1'b0);
                end
            end
            PH_LEN: begin
                if (ps_cr_held) begin
                    if (b == CH_LF) begin
                        finish_length();
                        done = 1'b1;
                    end else begin
                        length_char(CH_CR);
                        ps_cr_held = 1'b0;
                    end
                end
                if (!done) begin
                    if (b == CH_CR)
                        ps_cr_held = 1'b1;
                    else
                        length_char(b);
                end
            end
            PH_BULK: begin
                ps_count = (ps_count - 1) & LEN_SAT;
                if (ps_count == 0) begin
                    add_result(KIND_BULK, b, 1'b1, 1'b1);
                    ps_phase   = PH_TRAILER;
                    ps_trailer = TRAILER_LEN;
                end else begin
                    add_result(KIND_BULK, b, 1'b1, 1'b0);
                end
            end
            PH_TRAILER: begin
                ps_trailer = ps_trailer - 2'd1;
                if (ps_trailer == 2'd0)
                    clear_parse();
            end
            PH_DROP: begin
            end
            default: begin
                clear_parse();
                if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON) begin
                    ps_phase = PH_LINE;
                    ps_kind  = (b == CH_PLUS) ? KIND_SIMPLE :
                               (b == CH_MINUS) ? KIND_ERROR : KIND_INTEGER;
                end else if (b == CH_DOLLAR) begin
                    ps_phase = PH_LEN;
                    ps_kind  = KIND_BULK;
                end
            end
        endcase
        // buffer end: an open token is reported, a held CR is dropped
        if (eob) begin
            if (ps_phase == PH_LINE || ps_phase == PH_LEN || ps_phase == PH_BULK)
                add_result(KIND_INCOMPLETE, 8'h00, 1'b0, 1'b1);
            clear_parse();
        end
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.last = 1'b1;
            byte_results.insert(byte_results.size(), r);
        end
    endfunction

    function automatic t_result marker(t_kind k);
        return '{k, 8'h00, 1'b0, 1'b1, 1'b1};
    endfunction

    // ------------------------------------------------------------------
    // random stream planning: mostly well-formed tokens, some noise and
    // buffers cut short at a random byte
    // ------------------------------------------------------------------
    function automatic void draft_text(string text);
        int i;
        for (i = 0; i < text.len(); i++)
            draft.insert(draft.size(), text[i]);
    endfunction

    function automatic void draft_line();
        int sel;
        sel = $urandom_range(0, 2);
        draft.insert(draft.size(), sel == 0 ? CH_PLUS : (sel == 1 ? CH_MINUS : CH_COLON));
        repeat ($urandom_range(0, 6)) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                draft.insert(draft.size(), CH_CR);         // lone cr inside content
            else if (sel < 4)
                draft.insert(draft.size(), 8'($urandom_range(0, 255)));
            else
                draft.insert(draft.size(), 8'($urandom_range(32, 126)));
        end
        draft.insert(draft.size(), CH_CR);
        draft.insert(draft.size(), CH_LF);
    endfunction

    function automatic void draft_bulk();
        longint unsigned n;
        string text;
        logic good;
        logic has_junk;
        logic [7:0] junk;
        int cap;
        n        = 0;
        good     = 1'b1;
        has_junk = 1'b0;
        junk     = 8'h00;
        text     = "";
        cap      = (bulk_limit < 5) ? int'(bulk_limit) : 5;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n    = $urandom_range(0, cap);
                text = $sformatf("%0d", n);
            end
            4: begin
                text = "-1";
                good = 1'b0;
            end
            5: text = "-0";
            6: begin
                // just above the limit, or far beyond saturation
                good = 1'b0;
                if ($urandom_range(0, 3) == 0)
                    text = "99999999999";
                else
                    text = $sformatf("%0d",
                        longint'(bulk_limit) + 1 + longint'($urandom_range(0, 9)));
            end
            7: begin
                good = 1'b0;
                case ($urandom_range(0, 5))
                    0: text = "";
                    1: text = "-";
                    2: text = $sformatf("-%0d", $urandom_range(2, 99));
                    3: text = "--1";
                    4: text = "+3";
                    default: text = "x";
                endcase
            end
            8: begin
                // a stray character stops the digits, later ones are ignored
                n        = $urandom_range(0, 3);
                text     = $sformatf("%0d", n);
                has_junk = 1'b1;
                case ($urandom_range(0, 3))
                    0: junk = CH_CR;
                    1: junk = CH_PLUS;
                    2: junk = CH_MINUS;
                    default: junk = 8'h78;
                endcase
                good = (n <= bulk_limit);
            end
            default: begin
                n    = $urandom_range(0, 3);
                text = $sformatf("00%0d", n);
                good = (n <= bulk_limit);
            end
        endcase
        draft.insert(draft.size(), CH_DOLLAR);
        draft_text(text);
        if (has_junk) begin
            draft.insert(draft.size(), junk);
            draft.insert(draft.size(), CH_ZERO + 8'd7);
        end
        draft.insert(draft.size(), CH_CR);
        draft.insert(draft.size(), CH_LF);
        if (good) begin
            repeat (n) draft.insert(draft.size(), 8'($urandom_range(0, 255)));
            draft.insert(draft.size(), 8'($urandom_range(0, 255)));
            draft.insert(draft.size(), 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void draft_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 3)) begin
            b = 8'($urandom_range(0, 255));
            // keep noise from opening a token
            if (b == CH_PLUS || b == CH_MINUS || b == CH_COLON || b == CH_DOLLAR)
                b = b ^ 8'h40;
            draft.insert(draft.size(), b);
        end
    endfunction

    function automatic void plan_buffer();
        int cut;
        int i;
        t_feed_byte fb;
        draft.delete();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: draft_line();
                5, 6, 7, 8:    draft_bulk();
                default:       draft_noise();
            endcase
        end
        // a quarter of the buffers end in the middle of something
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, draft.size());
            while (draft.size() > cut)
                void'(draft.pop_back());
        end
        for (i = 0; i < draft.size(); i++) begin
            fb = '{draft[i], (i == draft.size() - 1), 1'b0, NO_RESULT};
            feed_q.insert(feed_q.size(), fb);
        end
        buffers_planned++;
    endfunction

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall limit on the run
    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // input transactions feed the shadow parser; output transactions are
    // checked in order against what it predicted. both sit in one block so
    // a result can never be checked before its byte has been parsed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                resp_parse_byte(in_ch.data_byte, in_ch.end_of_buffer);
                bytes_accepted++;
                if (cur_item.typed)
                    pending_results.insert(pending_results.size(), cur_item.typed_res);
                else
                    foreach (byte_results[i])
                        pending_results.insert(pending_results.size(), byte_results[i]);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.kind       = out_ch.kind;
                got.out_byte   = out_ch.out_byte;
                got.byte_valid = out_ch.byte_valid;
                got.token_end  = out_ch.token_end;
                got.last       = out_ch.last;
                results_checked++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: kind %0d byte %02h",
                                 $realtime, got.kind, got.out_byte,
                                 " valid %0b end %0b last %0b",
                                 got.byte_valid, got.token_end, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                        got.byte_valid !== want.byte_valid ||
                        got.token_end !== want.token_end || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected kind %0d byte %02h valid %0b",
                                     $realtime, want.kind, want.out_byte, want.byte_valid,
                                     " end %0b last %0b, got kind %0d byte %02h",
                                     want.token_end, want.last, got.kind, got.out_byte,
                                     " valid %0b end %0b last %0b",
                                     got.byte_valid, got.token_end, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: stalls on a random 32-bit pattern, sometimes none
    // at all; on request it holds off for a long stretch so the result
    // queue fills up and the block has to stall its input
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] pattern;
        int slot;
        out_ch.ready = 1'b0;
        pattern = '1;
        slot    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (slot == 0) begin
                    case ($urandom_range(0, 3))
                        0: pattern = '1;
                        1: pattern = $urandom | $urandom;
                        2: pattern = $urandom;
                        default: pattern = $urandom & $urandom;
                    endcase
                end
                out_ch.ready <= pattern[slot];
                slot = (slot + 1) % 32;
            end
        end
    end

    // ------------------------------------------------------------------
    // byte sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_queued();
        int burst;
        int gap;
        while (feed_q.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && feed_q.size() > 0) begin
                @(negedge i_clk);
                cur_item = feed_q.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.data_byte     <= cur_item.data;
                in_ch.end_of_buffer <= cur_item.eob;
                do @(posedge i_clk); while (!in_ch.ready);
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // limit register write; the block must be idle
    task automatic write_limit(input logic [MAX_LEN_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        bulk_limit = value;
        limit_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // all results in, then a settle wait of SETTLE_CYCLES for bytes that cause none
    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int i;

        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.end_of_buffer = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        i_rst_n             = 1'b0;
        hold_req            = 1'b0;
        mismatches          = 0;
        results_checked     = 0;
        bytes_accepted      = 0;
        buffers_planned     = 0;
        limit_writes        = 0;
        cur_item            = '{8'h00, 1'b0, 1'b0, NO_RESULT};
        bulk_limit          = RESET_LIMIT;
        clear_parse();

        // directed stream; markers are typed in, content comes from the parser
        directed_rows = '{
            // simple string: byte extremes, held cr then content, cr lf end
            '{CH_PLUS,           1'b0, 1'b0, NO_RESULT},
            '{8'hFF,             1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{8'h00,             1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b0, 1'b1, marker(KIND_SIMPLE)},
            // null bulk
            '{CH_DOLLAR,         1'b0, 1'b0, NO_RESULT},
            '{CH_MINUS,          1'b0, 1'b0, NO_RESULT},
            '{CH_ZERO + 8'd1,    1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b0, 1'b1, marker(KIND_NULL)},
            // zero length bulk, then two unchecked trailer bytes
            '{CH_DOLLAR,         1'b0, 1'b0, NO_RESULT},
            '{CH_ZERO,           1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b0, 1'b1, marker(KIND_BULK)},
            '{8'h00,             1'b0, 1'b0, NO_RESULT},
            '{8'hFF,             1'b0, 1'b0, NO_RESULT},
            // length with no digits, then input dropped to buffer end
            '{CH_DOLLAR,         1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b0, 1'b1, marker(KIND_BAD_LENGTH)},
            '{CH_PLUS,           1'b0, 1'b0, NO_RESULT},
            '{CH_ZERO + 8'd7,    1'b1, 1'b0, NO_RESULT},
            // error line cut off with a cr still held
            '{CH_MINUS,          1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b1, 1'b1, marker(KIND_INCOMPLETE)},
            // integer line: a bare lf is content, then buffer end
            '{CH_COLON,          1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b1, 1'b0, NO_RESULT},
            // bulk content cut off by buffer end
            '{CH_DOLLAR,         1'b0, 1'b0, NO_RESULT},
            '{CH_ZERO + 8'd2,    1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b0, 1'b0, NO_RESULT},
            '{CH_LF,             1'b0, 1'b0, NO_RESULT},
            '{CH_CR,             1'b1, 1'b0, NO_RESULT}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            feed_q.insert(feed_q.size(), directed_rows[i]);
        send_queued();
        wait_idle();

        // random phases, each under its own limit: reset value, zero,
        // the top of the range, a small one and a random small one
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: write_limit('0);
                2: write_limit(TOP_LIMIT);
                3: write_limit(30'd3);
                4: write_limit(MAX_LEN_W'($urandom_range(1, 8)));
                default: begin
                end
            endcase
            if (ph == 1)
                hold_req = 1'b1;   // long output stall while bytes keep coming
            if (ph == 2) begin
                // sender stops halfway until every result is back
                while (feed_q.size() < PHASE_BYTES / 2) plan_buffer();
                send_queued();
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            while (feed_q.size() < PHASE_BYTES / ((ph == 2) ? 2 : 1)) plan_buffer();
            send_queued();
            wait_idle();
        end

        $display("%0d bytes in %0d random buffers plus a directed stream, %0d results checked",
                 bytes_accepted, buffers_planned, results_checked);
        $display("limit written %0d times from 0 to 2^30-1, with a long output stall",
                 limit_writes);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rtsp_pkg.sv
hw/rtl/rtsp_in_if.sv
hw/rtl/rtsp_out_if.sv
hw/rtl/rtsp_cfg_if.sv
hw/rtl/rtsp_queue.sv
hw/rtl/resp_token_stream_parser_core.sv
hw/rtl/rtsp_checker.sv
dv/tb_top.sv
